// ===== rtl/hsv_pkg.sv =====
package hsv_pkg;

   // Field widths.
   localparam int HUE_W  = 9;
   localparam int CHAN_W = 8;

   // Hue is split into sixty-degree sectors.
   localparam int SECTOR_DEG = 60;
   localparam int SECTOR_NUM = 6;
   localparam int REM_W      = 6;
   // Largest quotient of a 9-bit hue by sixty.
   localparam int QUO_MAX    = ((2 ** HUE_W) - 1) / SECTOR_DEG;
   localparam int QUO_W      = $clog2(QUO_MAX + 1);

   // Full scale of a channel and of the hue-weighted mixing terms.
   localparam int CHAN_MAX = (2 ** CHAN_W) - 1;
   localparam int Q_SCALE  = SECTOR_DEG * CHAN_MAX;
   localparam int MIX_W    = 14;

   // Rounding bias added before the floor division.
   localparam int Q_BIAS = Q_SCALE / 2;
   localparam int P_BIAS = CHAN_MAX / 2;

   // Numerator widths for the q/t terms and the p term.
   localparam int NQ_W = MIX_W + CHAN_W;
   localparam int XQ_W = NQ_W - 2;
   localparam int NP_W = 2 * CHAN_W;

   // Division by 15300 is done as a shift by two and a divide by 3825.
   localparam int Q_DIV    = Q_SCALE / 4;
   localparam int Q_SHIFT  = XQ_W;
   localparam int Q_RECIP  = (2 ** Q_SHIFT) / Q_DIV;
   localparam int Q_PROD_W = 28;

   // Division by 255 through its reciprocal.
   localparam int P_DIV    = CHAN_MAX;
   localparam int P_SHIFT  = NP_W;
   localparam int P_RECIP  = (2 ** P_SHIFT) / P_DIV;
   localparam int P_PROD_W = 24;

   // Hue sector, named after the two primaries or secondaries it spans.
   typedef enum logic [2:0] {
      SECTOR_RED_YEL = 3'd0,
      SECTOR_YEL_GRN = 3'd1,
      SECTOR_GRN_CYN = 3'd2,
      SECTOR_CYN_BLU = 3'd3,
      SECTOR_BLU_MAG = 3'd4,
      SECTOR_MAG_RED = 3'd5
   } sector_type;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// Each word passes the sector, mixing, scaling, estimate and output registers in order.
// Throughput: one word per cycle while the response side is ready.
// Depth is set by the two multiply stages and the reciprocal divide with its correction.
// The whole pipeline stalls together when a response word is held, so nothing is lost.
// Synchronous reset clears all stage valid bits; the datapath is not reset.
module hsv_to_rgb_converter
   import hsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [CHAN_W-1:0] req_saturation,
   input  logic [CHAN_W-1:0] req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue
);

   // Pipeline advances whenever the output register is empty or being drained.
   logic rsp_valid_ff;
   logic adv;
   assign adv       = rsp_ready || !rsp_valid_ff;
   assign req_ready = adv;

   // ---------------- Stage 1: sector and remainder of the hue ----------------
   logic [QUO_W-1:0]  quo;
   logic [REM_W-1:0]  rem1_in;
   sector_type        sec1_in;
   logic              val1_ff;
   logic [REM_W-1:0]  rem1_ff;
   sector_type        sec1_ff;
   logic [CHAN_W-1:0] sat1_ff;
   logic [CHAN_W-1:0] bri1_ff;

   // Count the sector boundaries at or below the hue; the compares are independent.
   always_comb begin
      quo = '0;
      for (int i = 1; i <= QUO_MAX; i++) begin
         if (req_hue >= HUE_W'(i * SECTOR_DEG)) begin
            quo = quo + QUO_W'(1);
         end
      end
      rem1_in = REM_W'(req_hue - HUE_W'(quo) * HUE_W'(SECTOR_DEG));
      if (quo >= QUO_W'(SECTOR_NUM)) begin
         sec1_in = sector_type'(3'(quo - QUO_W'(SECTOR_NUM)));
      end else begin
         sec1_in = sector_type'(3'(quo));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val1_ff <= 1'b0;
      end else if (adv) begin
         val1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem1_ff <= rem1_in;
         sec1_ff <= sec1_in;
         sat1_ff <= req_saturation;
         bri1_ff <= req_brightness;
      end
   end

   // ---------------- Stage 2: saturation-weighted mixing factors ----------------
   logic [MIX_W-1:0]  fq2_in;
   logic [MIX_W-1:0]  ft2_in;
   logic [CHAN_W-1:0] fp2_in;
   logic              val2_ff;
   logic [MIX_W-1:0]  fq2_ff;
   logic [MIX_W-1:0]  ft2_ff;
   logic [CHAN_W-1:0] fp2_ff;
   sector_type        sec2_ff;
   logic [CHAN_W-1:0] bri2_ff;

   always_comb begin
      fq2_in = MIX_W'(Q_SCALE) - MIX_W'(sat1_ff) * MIX_W'(rem1_ff);
      ft2_in = MIX_W'(Q_SCALE)
             - MIX_W'(sat1_ff) * MIX_W'(REM_W'(SECTOR_DEG) - rem1_ff);
      fp2_in = CHAN_W'(CHAN_MAX) - sat1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val2_ff <= 1'b0;
      end else if (adv) begin
         val2_ff <= val1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fq2_ff  <= fq2_in;
         ft2_ff  <= ft2_in;
         fp2_ff  <= fp2_in;
         sec2_ff <= sec1_ff;
         bri2_ff <= bri1_ff;
      end
   end

   // ---------------- Stage 3: scale by brightness and add rounding bias ----------------
   logic [NQ_W-1:0]   nq3_in;
   logic [NQ_W-1:0]   nt3_in;
   logic [NP_W-1:0]   np3_in;
   logic              val3_ff;
   logic [NQ_W-1:0]   nq3_ff;
   logic [NQ_W-1:0]   nt3_ff;
   logic [NP_W-1:0]   np3_ff;
   sector_type        sec3_ff;
   logic [CHAN_W-1:0] bri3_ff;

   always_comb begin
      nq3_in = NQ_W'(bri2_ff) * NQ_W'(fq2_ff) + NQ_W'(Q_BIAS);
      nt3_in = NQ_W'(bri2_ff) * NQ_W'(ft2_ff) + NQ_W'(Q_BIAS);
      np3_in = NP_W'(bri2_ff) * NP_W'(fp2_ff) + NP_W'(P_BIAS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val3_ff <= 1'b0;
      end else if (adv) begin
         val3_ff <= val2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nq3_ff  <= nq3_in;
         nt3_ff  <= nt3_in;
         np3_ff  <= np3_in;
         sec3_ff <= sec2_ff;
         bri3_ff <= bri2_ff;
      end
   end

   // ---------------- Stage 4: reciprocal estimate of the quotients ----------------
   // The estimate is the true quotient or one below it.
   logic [XQ_W-1:0]     xq4_in;
   logic [XQ_W-1:0]     xt4_in;
   logic [Q_PROD_W-1:0] pq4;
   logic [Q_PROD_W-1:0] pt4;
   logic [P_PROD_W-1:0] pp4;
   logic                val4_ff;
   logic [XQ_W-1:0]     xq4_ff;
   logic [XQ_W-1:0]     xt4_ff;
   logic [NP_W-1:0]     xp4_ff;
   logic [CHAN_W-1:0]   eq4_ff;
   logic [CHAN_W-1:0]   et4_ff;
   logic [CHAN_W-1:0]   ep4_ff;
   sector_type          sec4_ff;
   logic [CHAN_W-1:0]   bri4_ff;

   always_comb begin
      xq4_in = nq3_ff[NQ_W-1:2];
      xt4_in = nt3_ff[NQ_W-1:2];
      pq4    = Q_PROD_W'(xq4_in) * Q_PROD_W'(Q_RECIP);
      pt4    = Q_PROD_W'(xt4_in) * Q_PROD_W'(Q_RECIP);
      pp4    = P_PROD_W'(np3_ff) * P_PROD_W'(P_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val4_ff <= 1'b0;
      end else if (adv) begin
         val4_ff <= val3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xq4_ff  <= xq4_in;
         xt4_ff  <= xt4_in;
         xp4_ff  <= np3_ff;
         eq4_ff  <= pq4[Q_SHIFT+CHAN_W-1:Q_SHIFT];
         et4_ff  <= pt4[Q_SHIFT+CHAN_W-1:Q_SHIFT];
         ep4_ff  <= pp4[P_SHIFT+CHAN_W-1:P_SHIFT];
         sec4_ff <= sec3_ff;
         bri4_ff <= bri3_ff;
      end
   end

   // ---------------- Stage 5: quotient correction and sector permutation ----------------
   logic [XQ_W-1:0]   remq;
   logic [XQ_W-1:0]   remt;
   logic [NP_W-1:0]   remp;
   logic [CHAN_W-1:0] mq;
   logic [CHAN_W-1:0] mt;
   logic [CHAN_W-1:0] mp;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] blue_ff;

   // One compare and increment fixes an estimate that fell one short.
   always_comb begin
      remq = xq4_ff - XQ_W'(eq4_ff) * XQ_W'(Q_DIV);
      remt = xt4_ff - XQ_W'(et4_ff) * XQ_W'(Q_DIV);
      remp = xp4_ff - NP_W'(ep4_ff) * NP_W'(P_DIV);
      mq   = eq4_ff + CHAN_W'(remq >= XQ_W'(Q_DIV));
      mt   = et4_ff + CHAN_W'(remt >= XQ_W'(Q_DIV));
      mp   = ep4_ff + CHAN_W'(remp >= NP_W'(P_DIV));
   end

   // Standard HSV permutation of value and the three mixing terms.
   always_comb begin
      case (sec4_ff)
         SECTOR_RED_YEL: begin
            red_in = bri4_ff; green_in = mt;      blue_in = mp;
         end
         SECTOR_YEL_GRN: begin
            red_in = mq;      green_in = bri4_ff; blue_in = mp;
         end
         SECTOR_GRN_CYN: begin
            red_in = mp;      green_in = bri4_ff; blue_in = mt;
         end
         SECTOR_CYN_BLU: begin
            red_in = mp;      green_in = mq;      blue_in = bri4_ff;
         end
         SECTOR_BLU_MAG: begin
            red_in = mt;      green_in = mp;      blue_in = bri4_ff;
         end
         default: begin
            red_in = bri4_ff; green_in = mp;      blue_in = mq;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= val4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // ---------------- Checks ----------------
   // The reciprocal estimates are never more than one short.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      val4_ff |-> (remq < XQ_W'(2 * Q_DIV)) && (remt < XQ_W'(2 * Q_DIV))
                  && (remp < NP_W'(2 * P_DIV)))
      else $error("quotient estimate out of range");

   // No mixing term exceeds the brightness.
   a_mix_le_value: assert property (@(posedge clock) disable iff (reset)
      val4_ff |-> (mq <= bri4_ff) && (mt <= bri4_ff) && (mp <= bri4_ff))
      else $error("mixing term above brightness");

   // A word leaving stage four reaches the output register.
   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      val4_ff && adv |=> rsp_valid_ff)
      else $error("word dropped at output stage");

   // Input is only held off while a response word is waiting.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

// ===== test/tb_hsv_to_rgb_converter.sv =====
module tb_hsv_to_rgb_converter;
   import hsv_pkg::*;

   // Full scale of a channel and of the hue-weighted mixing terms.
   localparam int unsigned FULL_SCALE = 255;
   localparam int unsigned MIX_SCALE  = 60 * 255;
   localparam int unsigned DEG_PER_SECTOR = 60;
   localparam int unsigned SECTOR_COUNT   = 6;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [HUE_W-1:0]  req_hue = '0;
   logic [CHAN_W-1:0] req_saturation = '0;
   logic [CHAN_W-1:0] req_brightness = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_red;
   logic [CHAN_W-1:0] rsp_green;
   logic [CHAN_W-1:0] rsp_blue;

   // Pixels predicted for accepted request words, oldest first.
   rgb_type pending_rgb[$];
   int      errors = 0;

   // Sender pacing, owned by the stimulus thread.
   bit gaps_on    = 1'b0;
   int burst_left = 0;

   // Receiver controls: stall pattern enable and a one-shot long hold-off.
   logic stall_on     = 1'b0;
   logic hold_pending = 1'b0;
   int   hold_len     = 0;
   int   hold_left    = 0;
   int   run_left     = 0;

   hsv_to_rgb_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact integer HSV to RGB conversion with round half up.
   function automatic rgb_type hsv_to_rgb(input logic [HUE_W-1:0] h,
                                          input logic [CHAN_W-1:0] s,
                                          input logic [CHAN_W-1:0] v);
      int unsigned hv, sv, vv, rem, mix_p, mix_q, mix_t;
      sector_type  sector;
      rgb_type     rgb;
      hv = 32'(h);
      sv = 32'(s);
      vv = 32'(v);
      sector = sector_type'(3'((hv / DEG_PER_SECTOR) % SECTOR_COUNT));
      rem = hv % DEG_PER_SECTOR;
      mix_p = (2 * vv * (FULL_SCALE - sv) + FULL_SCALE) / (2 * FULL_SCALE);
      mix_q = (2 * vv * (MIX_SCALE - sv * rem) + MIX_SCALE) / (2 * MIX_SCALE);
      mix_t = (2 * vv * (MIX_SCALE - sv * (DEG_PER_SECTOR - rem)) + MIX_SCALE)
              / (2 * MIX_SCALE);
      // The sector picks which channel gets value, p, q or t.
      case (sector)
         SECTOR_RED_YEL: begin
            rgb.red = CHAN_W'(vv); rgb.green = CHAN_W'(mix_t);
            rgb.blue = CHAN_W'(mix_p);
         end
         SECTOR_YEL_GRN: begin
            rgb.red = CHAN_W'(mix_q); rgb.green = CHAN_W'(vv);
            rgb.blue = CHAN_W'(mix_p);
         end
         SECTOR_GRN_CYN: begin
            rgb.red = CHAN_W'(mix_p); rgb.green = CHAN_W'(vv);
            rgb.blue = CHAN_W'(mix_t);
         end
         SECTOR_CYN_BLU: begin
            rgb.red = CHAN_W'(mix_p); rgb.green = CHAN_W'(mix_q);
            rgb.blue = CHAN_W'(vv);
         end
         SECTOR_BLU_MAG: begin
            rgb.red = CHAN_W'(mix_t); rgb.green = CHAN_W'(mix_p);
            rgb.blue = CHAN_W'(vv);
         end
         default: begin
            rgb.red = CHAN_W'(vv); rgb.green = CHAN_W'(mix_p);
            rgb.blue = CHAN_W'(mix_q);
         end
      endcase
      return rgb;
   endfunction

   // Receiver: a long hold-off when asked, else random ready and stall
   // stretches, else always ready.
   always @(posedge clock) begin
      if (hold_pending) begin
         hold_pending <= 1'b0;
         hold_left    <= hold_len;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!stall_on) begin
         rsp_ready <= 1'b1;
      end else if (run_left != 0) begin
         run_left <= run_left - 1;
      end else begin
         rsp_ready <= !rsp_ready;
         run_left  <= rsp_ready ? $urandom_range(0, 5) : $urandom_range(0, 7);
      end
   end

   // Compare every accepted response word with the oldest prediction.
   always @(posedge clock) begin : check_pixels
      rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rgb.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, got r=%0d g=%0d b=%0d",
                     $time, rsp_red, rsp_green, rsp_blue);
         end else begin
            want = pending_rgb.pop_front();
            if (want.red !== rsp_red || want.green !== rsp_green ||
                want.blue !== rsp_blue) begin
               errors++;
               $display("%0t: mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        $time, want.red, want.green, want.blue,
                        rsp_red, rsp_green, rsp_blue);
            end
         end
      end
   end

   // Offer one request word, with burst gaps when enabled, and wait for it.
   task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [CHAN_W-1:0] s,
                             input logic [CHAN_W-1:0] v);
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
      end
      req_valid      <= 1'b1;
      req_hue        <= h;
      req_saturation <= s;
      req_brightness <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rgb.push_back(hsv_to_rgb(h, s, v));
   endtask

   // Random pixel biased toward the field extremes and sector edges.
   task automatic send_random_pixel();
      logic [HUE_W-1:0]  h;
      logic [CHAN_W-1:0] s;
      logic [CHAN_W-1:0] v;
      case ($urandom_range(0, 15))
         0:       h = HUE_W'($urandom_range(361, 511));
         1:       h = HUE_W'(DEG_PER_SECTOR * $urandom_range(0, 6));
         default: h = HUE_W'($urandom_range(0, 360));
      endcase
      case ($urandom_range(0, 7))
         0:       s = '0;
         1:       s = '1;
         default: s = CHAN_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = '1;
         default: v = CHAN_W'($urandom_range(0, 255));
      endcase
      send_pixel(h, s, v);
   endtask

   // Stop offering words and wait until every prediction has been met.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rgb.size() != 0) @(posedge clock);
   endtask

   // Extremes, every sector and its edges, wrapped hues, grey and black.
   task automatic test_directed();
      send_pixel(9'd0,   8'd0,   8'd0);
      send_pixel(9'd0,   8'd255, 8'd255);
      send_pixel(9'd360, 8'd255, 8'd255);
      send_pixel(9'd359, 8'd255, 8'd255);
      send_pixel(9'd59,  8'd255, 8'd255);
      send_pixel(9'd60,  8'd255, 8'd255);
      send_pixel(9'd90,  8'd255, 8'd255);
      send_pixel(9'd120, 8'd255, 8'd255);
      send_pixel(9'd150, 8'd200, 8'd230);
      send_pixel(9'd180, 8'd255, 8'd255);
      send_pixel(9'd210, 8'd100, 8'd250);
      send_pixel(9'd240, 8'd255, 8'd255);
      send_pixel(9'd270, 8'd170, 8'd85);
      send_pixel(9'd300, 8'd255, 8'd255);
      send_pixel(9'd330, 8'd127, 8'd128);
      send_pixel(9'd361, 8'd200, 8'd180);
      send_pixel(9'd420, 8'd128, 8'd77);
      send_pixel(9'd511, 8'd255, 8'd255);
      send_pixel(9'd200, 8'd0,   8'd173);
      send_pixel(9'd17,  8'd255, 8'd0);
      send_pixel(9'd30,  8'd255, 8'd1);
      send_pixel(9'd45,  8'd1,   8'd255);
      send_pixel(9'd256, 8'd170, 8'd254);
      wait_drained();
   endtask

   // Random traffic with sender bursts and receiver stalls.
   task automatic test_random_traffic();
      stall_on <= 1'b1;
      gaps_on = 1'b1;
      repeat (300) send_random_pixel();
      gaps_on = 1'b0;
      stall_on <= 1'b0;
   endtask

   // A long receiver hold-off while the sender keeps offering words, so
   // the pipeline fills and stalls its input, then a full drain.
   task automatic test_backpressure();
      hold_len = 80;
      hold_pending <= 1'b1;
      repeat (30) send_random_pixel();
      wait_drained();
   endtask

   // Back to back at full rate with no stalls on either side.
   task automatic test_full_rate();
      repeat (100) send_random_pixel();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic();
      test_backpressure();
      test_full_rate();
      wait_drained();
      // Let the pipeline run empty to catch any stray words.
      repeat (12) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
